@@ src/binary_min_heap_queue_assert.svh @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_assert.svh
// Assertion macros for the binary min-heap queue. Empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, quiet while reset is high.
`define BMHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BMHQ_ASSERT(label, clk, rst, prop, msg)
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ src/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants and types of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   // Fixed field widths
   localparam int KEY_BITS    = 64;
   localparam int OCC_BITS    = 11;
   localparam int ACTION_BITS = 2;

   // Action codes of a request transaction
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_PEEK   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd3;

   // Sequencer states
   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_LOAD     = 12'b0000_0000_0010,
      ST_LOAD_W   = 12'b0000_0000_0100,
      ST_ROOT     = 12'b0000_0000_1000,
      ST_ROOT_W   = 12'b0000_0001_0000,
      ST_SD_START = 12'b0000_0010_0000,
      ST_SD_LEFT  = 12'b0000_0100_0000,
      ST_SD_RIGHT = 12'b0000_1000_0000,
      ST_SU_START = 12'b0001_0000_0000,
      ST_SU_CMP   = 12'b0010_0000_0000,
      ST_PUT      = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

endpackage

@@ src/bmhq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word into the registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/binary_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of key/tag entries with lazy delete-min.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_action, req_entry_key, req_entry_tag) is taken
//   when req_valid is high and req_stall is low. Every request yields exactly
//   one response transaction on the rsp_ channel, in request order.
//   Actions: insert, peek minimum, delete minimum, clear. Delete leaves a hole
//   at the root that the next insert, peek or delete fills with a sift down.
//   Entries live in one RAM (key and tag side by side); one item is handled
//   at a time by a read-modify-write sequencer.
//   Clear, reject and empty peek or delete go straight to the response; a
//   peek or delete without a hole reads the root directly; an insert into
//   the hole, or a peek or delete that fills it, walks a sift down, and any
//   other insert walks a sift up. The sift down reads left and right child
//   one after the other over the single RAM read port; a level without a
//   right child skips the second read.
//   Reset empties the queue and drops any pending response; RAM contents are
//   not cleared and are never read before written.
//   The response sits in an output register: the next request is taken while
//   it waits, and a stalled response holds until rsp_stall drops.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
   parameter int CAPACITY = 1024,
   parameter int TAG_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bmhq_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [bmhq_pkg::KEY_BITS-1:0]       req_entry_key,
   input  logic [TAG_BITS-1:0]                 req_entry_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [bmhq_pkg::KEY_BITS-1:0]       rsp_min_key,
   output logic [TAG_BITS-1:0]                 rsp_min_tag,
   output logic                                rsp_full_reject,
   output logic [bmhq_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   import bmhq_pkg::*;

`include "binary_min_heap_queue_assert.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam int EW = KEY_BITS + TAG_BITS;

   // Control state
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          hole_ff, hole_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers of one item
   logic                get_ff, get_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [AW-1:0]       i_ff, i_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [KEY_BITS-1:0] mv_key_ff, mv_key_in;
   logic [TAG_BITS-1:0] mv_tag_ff, mv_tag_in;
   logic [KEY_BITS-1:0] left_key_ff, left_key_in;
   logic [TAG_BITS-1:0] left_tag_ff, left_tag_in;
   logic                res_found_ff, res_found_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [TAG_BITS-1:0] res_tag_ff, res_tag_in;
   logic                res_rej_ff, res_rej_in;

   // Response register
   logic                rsp_found_ff, rsp_found_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic                rsp_rej_ff, rsp_rej_in;
   logic [OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   // RAM port
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   logic [KEY_BITS-1:0] rd_key;
   logic [TAG_BITS-1:0] rd_tag;

   // Sift-down helpers
   logic [XW-1:0]       n_ext;
   logic [XW-1:0]       r_ext;
   logic                has_right;
   logic                cmp_lr;
   logic                take_right;
   logic [KEY_BITS-1:0] cand_key;
   logic [TAG_BITS-1:0] cand_tag;
   logic [AW-1:0]       cand_idx;
   logic                go_down;
   logic [XW-1:0]       nl_ext;
   logic                next_has;
   logic [AW-1:0]       parent_idx;
   logic [AW-1:0]       parent_of_i;
   logic                full;
   logic [CW+OCC_BITS-1:0] occ_wide;
   logic [AW:0]         wr_addr_ext;

   bmhq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key = ram_rd_data[EW-1:TAG_BITS];
   assign rd_tag = ram_rd_data[TAG_BITS-1:0];

   // Pick the child to compare against; right wins only when strictly smaller
   assign n_ext      = {{(XW-CW){1'b0}}, n_ff};
   assign r_ext      = {2'b00, idx_ff} + XW'(1);
   assign has_right  = r_ext < n_ext;
   assign cmp_lr     = left_key_ff > rd_key;
   assign take_right = (state_ff == ST_SD_RIGHT) && cmp_lr;
   assign cand_key   = ((state_ff == ST_SD_LEFT) || take_right) ? rd_key : left_key_ff;
   assign cand_tag   = ((state_ff == ST_SD_LEFT) || take_right) ? rd_tag : left_tag_ff;
   assign cand_idx   = take_right ? (idx_ff + AW'(1)) : idx_ff;

   // Compare the moving entry with the smaller child (the left one alone when there is no right child)
   always_comb begin
      if (state_ff == ST_SD_RIGHT) begin
         go_down = cmp_lr ? (mv_key_ff > rd_key) : (mv_key_ff > left_key_ff);
      end else begin
         go_down = mv_key_ff > rd_key;
      end
   end

   assign nl_ext      = {1'b0, cand_idx, 1'b1};
   assign next_has    = nl_ext < n_ext;
   assign parent_idx  = (idx_ff - AW'(1)) >> 1;
   assign parent_of_i = (i_ff - AW'(1)) >> 1;
   assign full        = count_ff == CW'(CAPACITY);
   assign occ_wide    = {{OCC_BITS{1'b0}}, count_ff};
   assign wr_addr_ext = {1'b0, ram_wr_addr};

   // Sequence one item through the heap
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hole_in      = hole_ff;
      get_in       = get_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      idx_in       = idx_ff;
      mv_key_in    = mv_key_ff;
      mv_tag_in    = mv_tag_ff;
      left_key_in  = left_key_ff;
      left_tag_in  = left_tag_ff;
      res_found_in = res_found_ff;
      res_key_in   = res_key_ff;
      res_tag_in   = res_tag_ff;
      res_rej_in   = res_rej_ff;
      rsp_found_in = rsp_found_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = i_ff;
      ram_wr_data  = {mv_key_ff, mv_tag_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_found_in = 1'b0;
               res_key_in   = '0;
               res_tag_in   = '0;
               res_rej_in   = 1'b0;
               mv_key_in    = req_entry_key;
               mv_tag_in    = req_entry_tag;
               get_in       = 1'b0;
               state_in     = ST_FINISH;
               unique case (req_action)
                  ACT_INSERT: begin
                     if (full) begin
                        res_rej_in = 1'b1;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (hole_ff) begin
                           hole_in  = 1'b0;
                           n_in     = count_ff + CW'(1);
                           i_in     = '0;
                           state_in = ST_SD_START;
                        end else begin
                           i_in     = count_ff[AW-1:0];
                           state_in = ST_SU_START;
                        end
                     end
                  end
                  ACT_PEEK, ACT_DELETE: begin
                     get_in = 1'b1;
                     if (count_ff != '0) begin
                        res_found_in = 1'b1;
                        n_in         = count_ff;
                        hole_in      = req_action == ACT_DELETE;
                        if (req_action == ACT_DELETE) begin
                           count_in = count_ff - CW'(1);
                        end
                        state_in = hole_ff ? ST_LOAD : ST_ROOT;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     hole_in  = 1'b0;
                  end
               endcase
            end
         end

         // Fetch the last entry to fill the root hole
         ST_LOAD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = n_ff[AW-1:0];
            state_in    = ST_LOAD_W;
         end

         ST_LOAD_W: begin
            mv_key_in = rd_key;
            mv_tag_in = rd_tag;
            i_in      = '0;
            state_in  = ST_SD_START;
         end

         // Read the root directly
         ST_ROOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = ST_ROOT_W;
         end

         ST_ROOT_W: begin
            res_key_in = rd_key;
            res_tag_in = rd_tag;
            state_in   = ST_FINISH;
         end

         // Start the sift down at the root
         ST_SD_START: begin
            if (n_ext > XW'(1)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(1);
               idx_in      = AW'(1);
               state_in    = ST_SD_LEFT;
            end else begin
               state_in = ST_PUT;
            end
         end

         // Left child arrives; fetch right child or decide on the left alone
         ST_SD_LEFT, ST_SD_RIGHT: begin
            if ((state_ff == ST_SD_LEFT) && has_right) begin
               left_key_in = rd_key;
               left_tag_in = rd_tag;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + AW'(1);
               state_in    = ST_SD_RIGHT;
            end else if (go_down) begin
               // Move the child up, descend
               ram_wr_en   = 1'b1;
               ram_wr_data = {cand_key, cand_tag};
               if (get_ff && (i_ff == '0)) begin
                  res_key_in = cand_key;
                  res_tag_in = cand_tag;
               end
               i_in = cand_idx;
               if (next_has) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = nl_ext[AW-1:0];
                  idx_in      = nl_ext[AW-1:0];
                  state_in    = ST_SD_LEFT;
               end else begin
                  state_in = ST_PUT;
               end
            end else begin
               // Settle the moving entry here
               ram_wr_en = 1'b1;
               if (get_ff && (i_ff == '0)) begin
                  res_key_in = mv_key_ff;
                  res_tag_in = mv_tag_ff;
               end
               state_in = ST_FINISH;
            end
         end

         // Start the sift up at the new slot
         ST_SU_START: begin
            if (i_ff == '0) begin
               state_in = ST_PUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent_of_i;
               idx_in      = parent_of_i;
               state_in    = ST_SU_CMP;
            end
         end

         // Parent arrives; pull it down while strictly greater
         ST_SU_CMP: begin
            ram_wr_en = 1'b1;
            if (rd_key > mv_key_ff) begin
               ram_wr_data = ram_rd_data;
               i_in        = idx_ff;
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = parent_idx;
                  idx_in      = parent_idx;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         // Write the moving entry at its final slot
         ST_PUT: begin
            ram_wr_en = 1'b1;
            if (get_ff && (i_ff == '0)) begin
               res_key_in = mv_key_ff;
               res_tag_in = mv_tag_ff;
            end
            state_in = ST_FINISH;
         end

         // Hand the result to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_key_in   = res_found_ff ? res_key_ff : '0;
               rsp_tag_in   = res_found_ff ? res_tag_ff : '0;
               rsp_rej_in   = res_rej_ff;
               rsp_occ_in   = occ_wide[OCC_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hole_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hole_ff      <= hole_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      get_ff       <= get_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      idx_ff       <= idx_in;
      mv_key_ff    <= mv_key_in;
      mv_tag_ff    <= mv_tag_in;
      left_key_ff  <= left_key_in;
      left_tag_ff  <= left_tag_in;
      res_found_ff <= res_found_in;
      res_key_ff   <= res_key_in;
      res_tag_ff   <= res_tag_in;
      res_rej_ff   <= res_rej_in;
      rsp_found_ff <= rsp_found_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_min_key     = rsp_key_ff;
   assign rsp_min_tag     = rsp_tag_ff;
   assign rsp_full_reject = rsp_rej_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   // Checks
   `BMHQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "entry count above capacity")
   `BMHQ_ASSERT(a_hole_room, clock, reset, hole_ff |-> (count_ff < CW'(CAPACITY)), "hole pending while full")
   `BMHQ_ASSERT(a_found_xor_rej, clock, reset, rsp_valid |-> !(rsp_found && rsp_full_reject), "found and reject together")
   `BMHQ_ASSERT(a_wr_in_range, clock, reset, ram_wr_en |-> (wr_addr_ext < (AW+1)'(CAPACITY)), "heap write beyond capacity")
   `BMHQ_ASSERT(a_idle_no_ram, clock, reset, (state_ff == ST_IDLE) |-> !ram_wr_en, "heap write while idle")

endmodule
